/* rtl/gnps_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the nearest point search.
`timescale 1ns / 1ps
`default_nettype none
package gnps_pkg;

   // Table geometry
   localparam int MAX_POINTS = 1024;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int ID_BITS    = 32;

   // Coordinate and arithmetic widths
   localparam int LAT_W   = 21;
   localparam int LON_W   = 22;
   localparam int ANG_W   = 23;
   localparam int TRIG_W  = 33;
   localparam int COS_W   = 32;
   localparam int SUM_W   = 34;
   localparam int STEP_W  = 5;

   // Angle reduction and CORDIC constants
   localparam int FULL_TURN    = 3600000;
   localparam int REM_W        = $clog2(FULL_TURN);
   localparam int CORDIC_STEPS = 30;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sh026DD3B6A;
   localparam logic signed [COS_W-1:0]  ONE_Q30     = 32'sh40000000;

   // One stored point
   typedef struct packed {
      logic signed [LAT_W-1:0] lat;
      logic signed [LON_W-1:0] lon;
      logic [ID_BITS-1:0]      id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Cosine and sine pair in Q2.30
   typedef struct packed {
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
   } trig_type;

   // Arctangent of 2^-i in 2^-32 turns
   function automatic logic signed [31:0] atan_turn(input logic [STEP_W-1:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:    v = 32'sh20000000;
         5'd1:    v = 32'sh12E4051D;
         5'd2:    v = 32'sh09FB385B;
         5'd3:    v = 32'sh051111D4;
         5'd4:    v = 32'sh028B0D43;
         5'd5:    v = 32'sh0145D7E1;
         5'd6:    v = 32'sh00A2F61E;
         5'd7:    v = 32'sh00517C55;
         5'd8:    v = 32'sh0028BE53;
         5'd9:    v = 32'sh00145F2F;
         5'd10:   v = 32'sh000A2F98;
         5'd11:   v = 32'sh000517CC;
         5'd12:   v = 32'sh00028BE6;
         5'd13:   v = 32'sh000145F3;
         5'd14:   v = 32'sh0000A2FA;
         5'd15:   v = 32'sh0000517D;
         5'd16:   v = 32'sh000028BE;
         5'd17:   v = 32'sh0000145F;
         5'd18:   v = 32'sh00000A30;
         5'd19:   v = 32'sh00000518;
         5'd20:   v = 32'sh0000028C;
         5'd21:   v = 32'sh00000146;
         5'd22:   v = 32'sh000000A3;
         5'd23:   v = 32'sh00000051;
         5'd24:   v = 32'sh00000029;
         5'd25:   v = 32'sh00000014;
         5'd26:   v = 32'sh0000000A;
         5'd27:   v = 32'sh00000005;
         5'd28:   v = 32'sh00000003;
         5'd29:   v = 32'sh00000001;
         default: v = 32'sh00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* rtl/gnps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gnps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/gnps_sincos.sv */
// Iterative sine and cosine unit: angle reduction, reciprocal turn scaling, 30-step CORDIC.
`timescale 1ns / 1ps
`default_nettype none
module gnps_sincos (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic signed [gnps_pkg::ANG_W-1:0] angle,
   output logic                                 done,
   output gnps_pkg::trig_type                   result
);
   import gnps_pkg::*;

   localparam int RED_W  = ANG_W + 1;
   localparam int FIX_W  = REM_W + 2;
   localparam int RCP_W  = 31;
   localparam int RCP_SH = 20;
   localparam logic signed [RED_W-1:0] TURN_T   = RED_W'(FULL_TURN);
   localparam logic [REM_W-1:0]        TURN_R   = REM_W'(FULL_TURN);
   localparam logic [FIX_W-1:0]        TURN_F   = FIX_W'(FULL_TURN);
   localparam logic [RCP_W-1:0]        RECIP    = RCP_W'(1250999896);
   localparam logic [STEP_W-1:0]       ROT_LAST = STEP_W'(CORDIC_STEPS - 1);

   typedef enum logic [5:0] {
      SC_IDLE = 6'b000001,
      SC_RED  = 6'b000010,
      SC_MUL  = 6'b000100,
      SC_REM  = 6'b001000,
      SC_FIX  = 6'b010000,
      SC_ROT  = 6'b100000
   } sc_state_type;

   sc_state_type             state_ff;
   logic                     done_ff;
   logic signed [RED_W-1:0]  t_ff;
   logic [FIX_W-1:0]         rem_ff;
   logic [31:0]              quo_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [TRIG_W-1:0] x_ff;
   logic signed [TRIG_W-1:0] y_ff;
   logic signed [31:0]       z_ff;
   logic [1:0]               quad_ff;
   trig_type                 result_ff;

   logic [REM_W+RCP_W-1:0]   rcp_prod;
   logic [REM_W+31:0]        quo_prod;
   logic [REM_W+31:0]        rem_full;
   logic signed [TRIG_W-1:0] x_sh;
   logic signed [TRIG_W-1:0] y_sh;
   logic signed [31:0]       atan_v;
   logic signed [TRIG_W-1:0] x_nx;
   logic signed [TRIG_W-1:0] y_nx;
   logic signed [31:0]       z_nx;
   trig_type                 rot_out;

   // Estimate angle * 2^32 / full turn by a reciprocal, then form the remainder
   assign rcp_prod = t_ff[REM_W-1:0] * RECIP;
   assign quo_prod = quo_ff * TURN_R;
   assign rem_full = {t_ff[REM_W-1:0], 32'b0} - quo_prod;

   // One CORDIC micro-rotation
   assign x_sh   = x_ff >>> step_ff;
   assign y_sh   = y_ff >>> step_ff;
   assign atan_v = atan_turn(step_ff);

   always_comb begin
      if (!z_ff[31]) begin
         x_nx = x_ff - y_sh;
         y_nx = y_ff + x_sh;
         z_nx = z_ff - atan_v;
      end else begin
         x_nx = x_ff + y_sh;
         y_nx = y_ff - x_sh;
         z_nx = z_ff + atan_v;
      end
   end

   // Rotate the result into its quadrant
   always_comb begin
      case (quad_ff)
         2'd0:    begin rot_out.c = x_nx;  rot_out.s = y_nx;  end
         2'd1:    begin rot_out.c = -y_nx; rot_out.s = x_nx;  end
         2'd2:    begin rot_out.c = -x_nx; rot_out.s = -y_nx; end
         default: begin rot_out.c = y_nx;  rot_out.s = -x_nx; end
      endcase
   end

   // Sequence reduction, scaling and rotation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            SC_IDLE: begin
               if (start) begin
                  t_ff     <= {angle[ANG_W-1], angle};
                  state_ff <= SC_RED;
               end
            end
            SC_RED: begin
               if (t_ff[RED_W-1]) begin
                  t_ff <= t_ff + TURN_T;
               end else if (t_ff >= TURN_T) begin
                  t_ff <= t_ff - TURN_T;
               end else begin
                  state_ff <= SC_MUL;
               end
            end
            // The estimate is at most two below the true quotient
            SC_MUL: begin
               quo_ff   <= rcp_prod[RCP_SH +: 32];
               state_ff <= SC_REM;
            end
            SC_REM: begin
               rem_ff   <= rem_full[FIX_W-1:0];
               state_ff <= SC_FIX;
            end
            SC_FIX: begin
               if (rem_ff >= TURN_F) begin
                  rem_ff <= rem_ff - TURN_F;
                  quo_ff <= quo_ff + 32'd1;
               end else begin
                  quad_ff  <= quo_ff[31:30];
                  z_ff     <= $signed({2'b00, quo_ff[29:0]});
                  x_ff     <= CORDIC_GAIN;
                  y_ff     <= '0;
                  step_ff  <= '0;
                  state_ff <= SC_ROT;
               end
            end
            SC_ROT: begin
               x_ff    <= x_nx;
               y_ff    <= y_nx;
               z_ff    <= z_nx;
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == ROT_LAST) begin
                  result_ff <= rot_out;
                  done_ff   <= 1'b1;
                  state_ff  <= SC_IDLE;
               end
            end
            default: state_ff <= SC_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
`default_nettype wire

/* rtl/gnps_cosdist.sv */
// Great-circle distance cosine from sine/cosine pairs, one shared multiplier over three multiply steps.
`timescale 1ns / 1ps
`default_nettype none
module gnps_cosdist (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              equal,
   input  wire gnps_pkg::trig_type                qry,
   input  wire gnps_pkg::trig_type                ent,
   input  wire logic signed [gnps_pkg::TRIG_W-1:0] cos_dlon,
   output logic                                   done,
   output logic signed [gnps_pkg::COS_W-1:0]      result
);
   import gnps_pkg::*;

   localparam logic signed [SUM_W:0] SUM_ONE = (SUM_W + 1)'(ONE_Q30);
   localparam logic signed [SUM_W:0] SUM_NEG = -SUM_ONE;

   typedef enum logic [4:0] {
      CD_IDLE = 5'b00001,
      CD_M1   = 5'b00010,
      CD_M2   = 5'b00100,
      CD_M3   = 5'b01000,
      CD_SUM  = 5'b10000
   } cd_state_type;

   cd_state_type               state_ff;
   logic                       done_ff;
   logic signed [SUM_W-1:0]    p1_ff;
   logic signed [TRIG_W-1:0]   t_ff;
   logic signed [SUM_W-1:0]    p2_ff;
   logic signed [COS_W-1:0]    result_ff;

   logic signed [TRIG_W-1:0]   mul_a;
   logic signed [TRIG_W-1:0]   mul_b;
   logic signed [2*TRIG_W-1:0] prod;
   logic signed [SUM_W:0]      sum;

   // Select multiplier operands by step
   always_comb begin
      unique case (state_ff)
         CD_M1:   begin mul_a = qry.s; mul_b = ent.s;    end
         CD_M2:   begin mul_a = qry.c; mul_b = ent.c;    end
         CD_M3:   begin mul_a = t_ff;  mul_b = cos_dlon; end
         default: begin mul_a = '0;    mul_b = '0;       end
      endcase
   end

   assign prod = mul_a * mul_b;
   assign sum  = {p1_ff[SUM_W-1], p1_ff} + {p2_ff[SUM_W-1], p2_ff};

   // Multiply, shift down by 30, add and clamp; equal inputs return one directly
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            CD_IDLE: begin
               if (start) begin
                  if (equal) begin
                     result_ff <= ONE_Q30;
                     done_ff   <= 1'b1;
                  end else begin
                     state_ff <= CD_M1;
                  end
               end
            end
            CD_M1: begin
               p1_ff    <= $signed(prod[30 +: SUM_W]);
               state_ff <= CD_M2;
            end
            CD_M2: begin
               t_ff     <= $signed(prod[30 +: TRIG_W]);
               state_ff <= CD_M3;
            end
            CD_M3: begin
               p2_ff    <= $signed(prod[30 +: SUM_W]);
               state_ff <= CD_SUM;
            end
            CD_SUM: begin
               if (sum > SUM_ONE) begin
                  result_ff <= ONE_Q30;
               end else if (sum < SUM_NEG) begin
                  result_ff <= -ONE_Q30;
               end else begin
                  result_ff <= $signed(sum[COS_W-1:0]);
               end
               done_ff  <= 1'b1;
               state_ff <= CD_IDLE;
            end
            default: state_ff <= CD_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
`default_nettype wire

/* rtl/geo_nearest_point_search.sv */
// Top level: latitude-sorted point table in RAM with insert, clear and nearest-point query.
// Clear, func 3, a dropped insert and an empty query go straight to the response; an insert
// shifts each entry of higher latitude up one slot. A query runs its trigonometry, passes
// entries while finding the start, then for each entry visited runs a latitude CORDIC, a gap
// check if a best exists, a longitude CORDIC and a distance step; one item at a time.
// Synchronous reset empties the table at once; table RAM contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module geo_nearest_point_search (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_func,
   input  wire logic [31:0]                      req_point_id,
   input  wire logic signed [gnps_pkg::LAT_W-1:0] req_latitude,
   input  wire logic signed [gnps_pkg::LON_W-1:0] req_longitude,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_found,
   output logic [31:0]                           rsp_nearest_id,
   output logic [10:0]                           rsp_points_visited,
   output logic [10:0]                           rsp_stored_count,
   output logic [1:0]                            rsp_status
);
   import gnps_pkg::*;

   localparam logic [1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [1:0] FUNC_INSERT  = 2'd1;
   localparam logic [1:0] FUNC_QUERY   = 2'd2;
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [14:0] {
      ST_IDLE    = 15'b000000000000001,
      ST_INS_RD  = 15'b000000000000010,
      ST_INS_CMP = 15'b000000000000100,
      ST_Q_TRIGW = 15'b000000000001000,
      ST_Q_ZEROW = 15'b000000000010000,
      ST_F_RD    = 15'b000000000100000,
      ST_F_CMP   = 15'b000000001000000,
      ST_S_NEXT  = 15'b000000010000000,
      ST_S_LD    = 15'b000000100000000,
      ST_S_SB    = 15'b000001000000000,
      ST_S_GAP   = 15'b000010000000000,
      ST_S_DLW   = 15'b000100000000000,
      ST_S_W     = 15'b001000000000000,
      ST_S_FINAL = 15'b010000000000000,
      ST_FINISH  = 15'b100000000000000
   } state_type;

   // Control state
   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    rsp_valid_ff;

   // Item and scan state
   logic [ID_BITS-1:0]      qid_ff;
   logic signed [LAT_W-1:0] qlat_ff;
   logic signed [LON_W-1:0] qlon_ff;
   logic [CNT_W-1:0]        p_ff;
   logic [CNT_W-1:0]        j_ff;
   logic                    dir_ff;
   trig_type                qry_trig_ff;
   trig_type                ent_trig_ff;
   logic signed [TRIG_W-1:0] c0_ff;
   logic signed [TRIG_W-1:0] dl_cos_ff;
   logic signed [LAT_W-1:0] lat_e_ff;
   logic signed [LON_W-1:0] lon_e_ff;
   logic [ID_BITS-1:0]      id_e_ff;
   logic                    vl_ff;
   logic                    vr_ff;
   logic signed [COS_W-1:0] cl_ff;
   logic signed [COS_W-1:0] cr_ff;
   logic [ID_BITS-1:0]      il_ff;
   logic [ID_BITS-1:0]      ir_ff;
   logic                    found_ff;
   logic [ID_BITS-1:0]      nid_ff;
   logic [CNT_W-1:0]        visited_ff;
   logic [1:0]              status_ff;

   // Output register
   logic                    rsp_found_ff;
   logic [31:0]             rsp_nearest_id_ff;
   logic [10:0]             rsp_points_visited_ff;
   logic [10:0]             rsp_stored_count_ff;
   logic [1:0]              rsp_status_ff;

   // RAM and unit strobes
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [ENTRY_W-1:0]      wr_data;
   logic [IDX_W-1:0]        rd_addr;
   logic [ENTRY_W-1:0]      rd_data;
   entry_type               rd_entry;
   entry_type               new_entry;
   logic                    sc_start;
   logic signed [ANG_W-1:0] sc_angle;
   logic                    sc_done;
   trig_type                sc_result;
   logic                    cd_start;
   logic                    cd_equal;
   logic signed [TRIG_W-1:0] cd_cos_dlon;
   logic                    cd_done;
   logic signed [COS_W-1:0] cd_result;

   logic                    req_accept;
   logic [CNT_W-1:0]        p_dec;
   logic [CNT_W-1:0]        count_last;
   logic                    ins_shift;
   logic                    best_v;
   logic signed [COS_W-1:0] best_c;
   logic                    gap_break;
   logic                    lat_eq;
   logic                    lon_eq;
   logic signed [ANG_W-1:0] dlon;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);

   assign rd_entry      = entry_type'(rd_data);
   assign new_entry.lat = qlat_ff;
   assign new_entry.lon = qlon_ff;
   assign new_entry.id  = qid_ff;

   assign p_dec      = p_ff - CNT_W'(1);
   assign count_last = count_ff - CNT_W'(1);
   assign ins_shift  = rd_entry.lat > qlat_ff;
   assign best_v     = dir_ff ? vr_ff : vl_ff;
   assign best_c     = dir_ff ? cr_ff : cl_ff;
   assign gap_break  = best_c > cd_result;
   assign lat_eq     = (qlat_ff == lat_e_ff);
   assign lon_eq     = (qlon_ff == lon_e_ff);
   assign dlon       = {qlon_ff[LON_W-1], qlon_ff} - {lon_e_ff[LON_W-1], lon_e_ff};

   // Longitude cosine for the gap check or for the full distance
   assign cd_cos_dlon = (state_ff == ST_S_W) ? dl_cos_ff : c0_ff;

   // Drive RAM ports and unit starts
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = p_ff[IDX_W-1:0];
      wr_data  = new_entry;
      rd_addr  = '0;
      sc_start = 1'b0;
      sc_angle = '0;
      cd_start = 1'b0;
      cd_equal = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_func == FUNC_QUERY) && (count_ff != '0)) begin
               sc_start = 1'b1;
               sc_angle = {{(ANG_W - LAT_W){req_latitude[LAT_W-1]}}, req_latitude};
            end
         end
         ST_INS_RD: begin
            if (p_ff == '0) begin
               wr_en = 1'b1;
            end else begin
               rd_addr = p_dec[IDX_W-1:0];
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (ins_shift) begin
               wr_data = rd_data;
            end
         end
         ST_Q_TRIGW: begin
            sc_start = sc_done;
         end
         ST_F_RD: begin
            rd_addr = j_ff[IDX_W-1:0];
         end
         ST_S_NEXT: begin
            if (!dir_ff) begin
               rd_addr = p_dec[IDX_W-1:0];
            end else begin
               rd_addr = p_ff[IDX_W-1:0];
            end
         end
         ST_S_LD: begin
            sc_start = 1'b1;
            sc_angle = {{(ANG_W - LAT_W){rd_entry.lat[LAT_W-1]}}, rd_entry.lat};
         end
         ST_S_SB: begin
            if (sc_done) begin
               if (best_v) begin
                  cd_start = 1'b1;
                  cd_equal = lat_eq;
               end else begin
                  sc_start = 1'b1;
                  sc_angle = dlon;
               end
            end
         end
         ST_S_GAP: begin
            if (cd_done && !gap_break) begin
               sc_start = 1'b1;
               sc_angle = dlon;
            end
         end
         ST_S_DLW: begin
            if (sc_done) begin
               cd_start = 1'b1;
               cd_equal = lat_eq && lon_eq;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequence clear, insert and query
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  qid_ff     <= ID_BITS'(req_point_id);
                  qlat_ff    <= req_latitude;
                  qlon_ff    <= req_longitude;
                  found_ff   <= 1'b0;
                  nid_ff     <= '0;
                  visited_ff <= '0;
                  status_ff  <= STATUS_OK;
                  case (req_func)
                     FUNC_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= ST_FINISH;
                     end
                     FUNC_INSERT: begin
                        if (count_ff >= CNT_W'(MAX_POINTS)) begin
                           status_ff <= STATUS_FULL;
                           state_ff  <= ST_FINISH;
                        end else begin
                           p_ff     <= count_ff;
                           state_ff <= ST_INS_RD;
                        end
                     end
                     FUNC_QUERY: begin
                        if (count_ff == '0) begin
                           status_ff <= STATUS_EMPTY;
                           state_ff  <= ST_FINISH;
                        end else begin
                           state_ff <= ST_Q_TRIGW;
                        end
                     end
                     default: state_ff <= ST_FINISH;
                  endcase
               end
            end
            // Shift larger latitudes up one slot until the new point fits
            ST_INS_RD: begin
               if (p_ff == '0) begin
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_INS_CMP;
               end
            end
            ST_INS_CMP: begin
               if (ins_shift) begin
                  p_ff     <= p_dec;
                  state_ff <= ST_INS_RD;
               end else begin
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= ST_FINISH;
               end
            end
            // Query trigonometry and the cosine of a zero longitude difference
            ST_Q_TRIGW: begin
               if (sc_done) begin
                  qry_trig_ff <= sc_result;
                  state_ff    <= ST_Q_ZEROW;
               end
            end
            ST_Q_ZEROW: begin
               if (sc_done) begin
                  c0_ff    <= sc_result.c;
                  j_ff     <= '0;
                  vl_ff    <= 1'b0;
                  vr_ff    <= 1'b0;
                  state_ff <= ST_F_RD;
               end
            end
            // Find the first entry at or above the query latitude, or else the last entry
            ST_F_RD: begin
               if (j_ff == count_last) begin
                  p_ff     <= j_ff;
                  dir_ff   <= 1'b0;
                  state_ff <= ST_S_NEXT;
               end else begin
                  state_ff <= ST_F_CMP;
               end
            end
            ST_F_CMP: begin
               if (rd_entry.lat < qlat_ff) begin
                  j_ff     <= j_ff + CNT_W'(1);
                  state_ff <= ST_F_RD;
               end else begin
                  p_ff     <= j_ff;
                  dir_ff   <= 1'b0;
                  state_ff <= ST_S_NEXT;
               end
            end
            // Pick the next entry of the downward, then the upward scan
            ST_S_NEXT: begin
               if (!dir_ff) begin
                  if (p_ff == '0) begin
                     p_ff   <= j_ff;
                     dir_ff <= 1'b1;
                  end else begin
                     p_ff     <= p_dec;
                     state_ff <= ST_S_LD;
                  end
               end else if (p_ff == count_ff) begin
                  state_ff <= ST_S_FINAL;
               end else begin
                  state_ff <= ST_S_LD;
               end
            end
            ST_S_LD: begin
               lat_e_ff   <= rd_entry.lat;
               lon_e_ff   <= rd_entry.lon;
               id_e_ff    <= rd_entry.id;
               visited_ff <= visited_ff + CNT_W'(1);
               state_ff   <= ST_S_SB;
            end
            ST_S_SB: begin
               if (sc_done) begin
                  ent_trig_ff <= sc_result;
                  state_ff    <= best_v ? ST_S_GAP : ST_S_DLW;
               end
            end
            // End the scan on this side once the latitude gap alone is farther than its best
            ST_S_GAP: begin
               if (cd_done) begin
                  if (gap_break) begin
                     if (!dir_ff) begin
                        p_ff     <= j_ff;
                        dir_ff   <= 1'b1;
                        state_ff <= ST_S_NEXT;
                     end else begin
                        state_ff <= ST_S_FINAL;
                     end
                  end else begin
                     state_ff <= ST_S_DLW;
                  end
               end
            end
            ST_S_DLW: begin
               if (sc_done) begin
                  dl_cos_ff <= sc_result.c;
                  state_ff  <= ST_S_W;
               end
            end
            // Keep the nearer point; a tie keeps the earlier one
            ST_S_W: begin
               if (cd_done) begin
                  if (!best_v || (cd_result > best_c)) begin
                     if (dir_ff) begin
                        cr_ff <= cd_result;
                        ir_ff <= id_e_ff;
                        vr_ff <= 1'b1;
                     end else begin
                        cl_ff <= cd_result;
                        il_ff <= id_e_ff;
                        vl_ff <= 1'b1;
                     end
                  end
                  if (dir_ff) begin
                     p_ff <= p_ff + CNT_W'(1);
                  end
                  state_ff <= ST_S_NEXT;
               end
            end
            // Upward side wins unless the downward side is strictly nearer
            ST_S_FINAL: begin
               if (vr_ff && (!vl_ff || (cl_ff <= cr_ff))) begin
                  found_ff <= 1'b1;
                  nid_ff   <= ir_ff;
               end else if (vl_ff) begin
                  found_ff <= 1'b1;
                  nid_ff   <= il_ff;
               end
               state_ff <= ST_FINISH;
            end
            // Hand the transaction to the output register once it is free
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_found_ff          <= found_ff;
                  rsp_nearest_id_ff     <= 32'(nid_ff);
                  rsp_points_visited_ff <= 11'(visited_ff);
                  rsp_stored_count_ff   <= 11'(count_ff);
                  rsp_status_ff         <= status_ff;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   gnps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gnps_sincos u_sincos (
      .clock  (clock),
      .reset  (reset),
      .start  (sc_start),
      .angle  (sc_angle),
      .done   (sc_done),
      .result (sc_result)
   );

   gnps_cosdist u_cosdist (
      .clock    (clock),
      .reset    (reset),
      .start    (cd_start),
      .equal    (cd_equal),
      .qry      (qry_trig_ff),
      .ent      (ent_trig_ff),
      .cos_dlon (cd_cos_dlon),
      .done     (cd_done),
      .result   (cd_result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_nearest_id     = rsp_nearest_id_ff;
   assign rsp_points_visited = rsp_points_visited_ff;
   assign rsp_stored_count   = rsp_stored_count_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
`default_nettype wire
